// ===== rtl/fixed_decimal_number_formatter_unit_defines.svh =====
// Assertion macros shared by the formatter RTL.
`ifndef FIXED_DECIMAL_NUMBER_FORMATTER_UNIT_DEFINES_SVH
`define FIXED_DECIMAL_NUMBER_FORMATTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checks a condition at every clock edge outside reset.
`define FDNF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fdnf assertion failed");
// Checks that an antecedent implies a consequent in the same cycle.
`define FDNF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdnf assertion failed");
// Checks that an antecedent implies a consequent in the next cycle.
`define FDNF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdnf assertion failed");
`else
`define FDNF_ASSERT_ALWAYS(lbl, cond)
`define FDNF_ASSERT_IMPLY(lbl, ante, cons)
`define FDNF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/fdnf_pkg.sv =====
// Types and constants of the fixed decimal number formatter.
package fdnf_pkg;

  // ASCII codes emitted by the formatter.
  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_POINT = 7'd46;
  localparam logic [6:0] ASCII_MINUS = 7'd45;

  // Five decimal digits cover a 16-bit magnitude.
  localparam int DIGIT_COUNT = 5;
  localparam int RADIX       = 10;

  // Divide by ten: q = (x * 52429) >> 19 is exact for every 16-bit x.
  localparam logic [15:0] RECIP_TEN  = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef logic [3:0] digit_t;
  typedef logic [2:0] pos_t;
  typedef digit_t [DIGIT_COUNT-1:0] digits_t;

  // One item as it moves through the digit extraction pipeline.
  typedef struct packed {
    logic               neg;
    logic signed [3:0]  fl;
    logic [1:0]         pl;
    logic [15:0]        quo;
    digits_t            digits;
  } stage_t;

  // One classified item handed from the front part to the character sequencer.
  typedef struct packed {
    logic    neg;
    digits_t digits;
    pos_t    pos0;
    pos_t    stop;
    logic    pt;
  } entry_t;

endpackage

// ===== rtl/fdnf_in_if.sv =====
// Input channel carrying one number to format per transaction.
interface fdnf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic signed [3:0]  field_length;
  logic [1:0]         decimal_places;

  modport source (output valid, output value, output field_length,
                  output decimal_places, input ready);
  modport sink (input valid, input value, input field_length,
                input decimal_places, output ready);
endinterface

// ===== rtl/fdnf_out_if.sv =====
// Result channel carrying one ASCII character per transaction.
interface fdnf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

// ===== rtl/fdnf_front.sv =====
// Front part: accepts numbers, extracts decimal digits and classifies the layout.
module fdnf_front (
  input  logic                clk,
  input  logic                rst_n,
  fdnf_in_if.sink             in_ch,
  output logic                push,
  output fdnf_pkg::entry_t    push_entry,
  input  logic                push_ready
);

  localparam int STAGES = fdnf_pkg::DIGIT_COUNT;

  fdnf_pkg::stage_t       st_r [STAGES];
  logic [STAGES-1:0]      v_r;
  fdnf_pkg::stage_t       st_nxt [STAGES];
  fdnf_pkg::stage_t       last_st;
  logic                   adv;

  // The whole pipeline moves when its tail is empty or the queue takes the tail.
  assign adv         = !v_r[STAGES-1] || push_ready;
  assign push        = v_r[STAGES-1] && push_ready;
  assign in_ch.ready = adv;

  // Entry stage: sign and magnitude. The most negative value maps to 32768.
  always_comb begin
    st_nxt[0].neg    = in_ch.value[15];
    st_nxt[0].quo    = in_ch.value[15] ? 16'(16'd0 - in_ch.value) : in_ch.value;
    st_nxt[0].fl     = in_ch.field_length;
    st_nxt[0].pl     = in_ch.decimal_places;
    st_nxt[0].digits = '0;
  end

  // Each later stage divides by ten once and keeps the remainder as a digit.
  for (genvar k = 1; k < STAGES; k++) begin : g_div
    localparam int DI = fdnf_pkg::DIGIT_COUNT - k;
    logic [31:0] prod;
    logic [15:0] q;
    logic [15:0] q_ten;
    logic [15:0] rem;

    always_comb begin
      prod  = st_r[k-1].quo * fdnf_pkg::RECIP_TEN;
      q     = 16'(prod >> fdnf_pkg::RECIP_SHIFT);
      q_ten = 16'({q, 3'b000}) + 16'({q, 1'b0});
      rem   = st_r[k-1].quo - q_ten;
      st_nxt[k]            = st_r[k-1];
      st_nxt[k].quo        = q;
      st_nxt[k].digits[DI] = rem[3:0];
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STAGES-2:0], in_ch.valid};
    end
    if (adv) begin
      for (int s = 0; s < STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  // Layout classification of the item leaving the pipeline.
  always_comb begin
    logic [2:0]        start;
    logic [2:0]        auto_start;
    logic [2:0]        flc;
    logic [1:0]        plc;
    logic [2:0]        stop;

    last_st           = st_r[STAGES-1];
    last_st.digits[0] = last_st.quo[3:0];

    // Auto length starts at the first nonzero digit, else at the ones digit.
    auto_start = 3'(fdnf_pkg::DIGIT_COUNT - 1);
    for (int i = fdnf_pkg::DIGIT_COUNT - 1; i >= 0; i--) begin
      if (last_st.digits[i] != '0) begin
        auto_start = 3'(i);
      end
    end

    // Fixed length is clamped to the range one to five.
    priority if (last_st.fl < 4'sd1) begin
      flc = 3'd1;
    end else if (last_st.fl > 4'sd5) begin
      flc = 3'd5;
    end else begin
      flc = last_st.fl[2:0];
    end

    start = (last_st.fl == -4'sd1) ? auto_start : 3'(3'(fdnf_pkg::DIGIT_COUNT) - flc);
    plc   = (last_st.pl == 2'd3) ? 2'd2 : last_st.pl;
    stop  = 3'(3'(fdnf_pkg::DIGIT_COUNT) - {1'b0, plc});

    push_entry.neg    = last_st.neg;
    push_entry.digits = last_st.digits;
    push_entry.pos0   = (start < stop) ? start : stop;
    push_entry.stop   = stop;
    push_entry.pt     = (plc != 2'd0);
  end

endmodule

// ===== rtl/fdnf_queue.sv =====
// Short queue between the front part and the character sequencer.
module fdnf_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fdnf_pkg::entry_t push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output fdnf_pkg::entry_t pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fdnf_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
      end
      priority if (push && !pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CW'(count_r - 1'b1);
      end else begin
        count_r <= count_r;
      end
    end
  end

endmodule

// ===== rtl/fdnf_back.sv =====
// Back part: walks one classified item and emits its characters one per cycle while the output is not stalled.
module fdnf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  fdnf_pkg::entry_t pop_entry,
  output logic             pop,
  fdnf_out_if.source       out_ch
);

  logic              active_r;
  logic              sign_pend_r;
  logic              pt_pend_r;
  fdnf_pkg::digits_t digits_r;
  fdnf_pkg::pos_t    pos_r;
  fdnf_pkg::pos_t    stop_r;
  logic              out_valid_r;
  logic [6:0]        char_r;
  logic              last_r;

  logic              out_free;
  logic [6:0]        char_nxt;
  logic              last_nxt;
  logic              emit_sign;
  logic              emit_point;

  assign out_free         = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = char_r;
  assign out_ch.last      = last_r;

  // Next character: sign first, the point just before the first fraction digit.
  always_comb begin
    emit_sign  = sign_pend_r;
    emit_point = !sign_pend_r && pt_pend_r && (pos_r == stop_r);
    priority if (emit_sign) begin
      char_nxt = fdnf_pkg::ASCII_MINUS;
      last_nxt = 1'b0;
    end else if (emit_point) begin
      char_nxt = fdnf_pkg::ASCII_POINT;
      last_nxt = 1'b0;
    end else begin
      char_nxt = fdnf_pkg::ASCII_ZERO + 7'(digits_r[pos_r]);
      last_nxt = (pos_r == 3'(fdnf_pkg::DIGIT_COUNT - 1));
    end
  end

  // A new item is taken when idle or in the cycle its predecessor ends.
  assign pop = pop_valid && (!active_r || (out_free && last_nxt));

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= active_r;
      end
      if (pop) begin
        active_r <= 1'b1;
      end else if (out_free && active_r && last_nxt) begin
        active_r <= 1'b0;
      end
    end

    // Payload and walk position; a newly taken item replaces the finished walk.
    if (out_free && active_r) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
    if (pop) begin
      sign_pend_r <= pop_entry.neg;
      pt_pend_r   <= pop_entry.pt;
      digits_r    <= pop_entry.digits;
      pos_r       <= pop_entry.pos0;
      stop_r      <= pop_entry.stop;
    end else if (out_free && active_r) begin
      priority if (emit_sign) begin
        sign_pend_r <= 1'b0;
      end else if (emit_point) begin
        pt_pend_r <= 1'b0;
      end else begin
        pos_r <= 3'(pos_r + 1'b1);
      end
    end
  end

endmodule

// ===== rtl/fixed_decimal_number_formatter_unit.sv =====
// The first character passes the digit pipeline, the queue and the sequencer's output register.
// Throughput: one character per cycle while the output is not stalled; a number has
// 1 to 7 characters, and the character sequencer sets the pace.
// The digit pipeline accepts a new number every cycle while the queue has room.
// Reset (synchronous, active low) clears valid bits, queue pointers and sequencer.
`include "fixed_decimal_number_formatter_unit_defines.svh"

module fixed_decimal_number_formatter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  fdnf_in_if.sink    in_ch,
  fdnf_out_if.source out_ch
);

  logic             push;
  logic             push_ready;
  fdnf_pkg::entry_t push_entry;
  logic             pop;
  logic             pop_valid;
  fdnf_pkg::entry_t pop_entry;

  // Digit extraction and layout classification.
  fdnf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decoupling queue.
  fdnf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // Character sequencer and output register.
  fdnf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // Every emitted character is a sign, a point or a decimal digit.
  `FDNF_ASSERT_IMPLY(a_char_legal, out_ch.valid, (out_ch.char_code == fdnf_pkg::ASCII_MINUS) || (out_ch.char_code == fdnf_pkg::ASCII_POINT) || ((out_ch.char_code >= fdnf_pkg::ASCII_ZERO) && (out_ch.char_code <= 7'(fdnf_pkg::ASCII_ZERO + 7'd9))))
  // A number always ends on a digit, never on a sign or a point.
  `FDNF_ASSERT_IMPLY(a_last_is_digit, out_ch.valid && out_ch.last, (out_ch.char_code != fdnf_pkg::ASCII_MINUS) && (out_ch.char_code != fdnf_pkg::ASCII_POINT))
  // The sequencer only takes an item that the queue holds.
  `FDNF_ASSERT_IMPLY(a_pop_nonempty, pop, pop_valid)
  // A point that was taken is followed by a digit of the same number.
  `FDNF_ASSERT_NEXT(a_point_then_digit, out_ch.valid && out_ch.ready && (out_ch.char_code == fdnf_pkg::ASCII_POINT), !out_ch.valid || (out_ch.char_code >= fdnf_pkg::ASCII_ZERO))

endmodule

// ===== bench/fixed_decimal_number_formatter_unit_test.sv =====
// Self-checking testbench for the fixed decimal number formatter unit.
`timescale 1ns / 1ps

module fixed_decimal_number_formatter_unit_test;

  // Generous bound on the run, in clock cycles.
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_NUMBERS = 207;
  localparam int DRAIN_CYCLES = 20;

  // Result-side stall behaviors.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  // Predicts the character stream of each number and checks the output against it.
  class char_scoreboard;
    typedef struct packed {
      logic [6:0] code;
      logic       tail;
    } glyph_t;

    glyph_t pending_chars[$];
    int errors;
    int chars_checked;
    int numbers;
    int negatives;
    int auto_numbers;

    function new();
      errors = 0;
      chars_checked = 0;
      numbers = 0;
      negatives = 0;
      auto_numbers = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    // Works out the characters that one accepted number produces.
    function void note_number(logic signed [15:0] value, logic signed [3:0] field_len,
                              logic [1:0] places);
      logic neg;
      logic [16:0] mag;
      int m;
      int digit[fdnf_pkg::DIGIT_COUNT];
      int fl;
      int pl;
      int lead;
      int stop;
      bit found;
      logic [6:0] codes[$];
      glyph_t g;

      neg = value[15];
      mag = neg ? (17'h10000 - {1'b0, value}) : {1'b0, value};
      m = mag;
      for (int i = fdnf_pkg::DIGIT_COUNT - 1; i >= 0; i--) begin
        digit[i] = m % fdnf_pkg::RADIX;
        m = m / fdnf_pkg::RADIX;
      end
      pl = (places > 2'd2) ? 2 : places;
      fl = field_len;

      // Auto length starts at the first nonzero digit, or at the ones digit for zero.
      if (fl == -1) begin
        lead = fdnf_pkg::DIGIT_COUNT - 1;
        found = 1'b0;
        for (int i = 0; i < fdnf_pkg::DIGIT_COUNT; i++) begin
          if (!found && digit[i] != 0) begin
            lead = i;
            found = 1'b1;
          end
        end
        auto_numbers++;
      end else begin
        if (fl < 1) fl = 1;
        if (fl > fdnf_pkg::DIGIT_COUNT) fl = fdnf_pkg::DIGIT_COUNT;
        lead = fdnf_pkg::DIGIT_COUNT - fl;
      end

      if (neg) begin
        codes.push_back(fdnf_pkg::ASCII_MINUS);
        negatives++;
      end
      stop = fdnf_pkg::DIGIT_COUNT - pl;
      for (int i = lead; i < stop; i++) codes.push_back(7'(fdnf_pkg::ASCII_ZERO + digit[i]));
      if (pl > 0) begin
        codes.push_back(fdnf_pkg::ASCII_POINT);
        for (int i = fdnf_pkg::DIGIT_COUNT - pl; i < fdnf_pkg::DIGIT_COUNT; i++)
          codes.push_back(7'(fdnf_pkg::ASCII_ZERO + digit[i]));
      end

      foreach (codes[i]) begin
        g.code = codes[i];
        g.tail = (i == codes.size() - 1);
        pending_chars.push_back(g);
      end
      numbers++;
    endfunction

    // Compares one output transaction with the oldest expected character.
    function void check_char(logic [6:0] code, logic tail);
      glyph_t g;

      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                 $time, code, tail);
        errors++;
        return;
      end
      g = pending_chars.pop_front();
      chars_checked++;
      if (code !== g.code) begin
        $display("%0t: char_code mismatch: expected %0d, actual %0d", $time, g.code, code);
        errors++;
      end
      if (tail !== g.tail) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, g.tail, tail);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int cycle_count = 0;
  int burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_mode_left = 0;
  char_scoreboard sb = new();

  fdnf_in_if in_ch ();
  fdnf_out_if out_ch ();

  fixed_decimal_number_formatter_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one number and waits for its input transaction, idling between bursts.
  task automatic drive_number(input logic signed [15:0] value,
                              input logic signed [3:0] field_len,
                              input logic [1:0] places);
    int gap;

    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.value <= value;
    in_ch.field_length <= field_len;
    in_ch.decimal_places <= places;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_number(value, field_len, places);
    burst_left--;
  endtask

  // Draws a random number, biased toward small values and auto length.
  task automatic drive_random_number();
    logic signed [15:0] value;
    logic signed [3:0] field_len;
    int pick;

    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      value = 16'($urandom_range(0, 199) - 99);
    end else if (pick == 3) begin
      case ($urandom_range(0, 4))
        0: value = 16'sh8000;
        1: value = 16'sh7fff;
        2: value = 16'sh0000;
        3: value = 16'shffff;
        default: value = 16'sh0001;
      endcase
    end else begin
      value = 16'($urandom());
    end
    field_len = ($urandom_range(0, 2) == 0) ? -4'sd1 : 4'($urandom_range(0, 15));
    drive_number(value, field_len, 2'($urandom_range(0, 3)));
  endtask

  // Result side: stalls on its own pattern and checks every output transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(8, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= ~out_ch.ready;
      endcase
      if (out_ch.valid && out_ch.ready) sb.check_char(out_ch.char_code, out_ch.last);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d characters outstanding.",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence: reset, directed corner cases, random numbers, drain.
  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.field_length <= '0;
    in_ch.decimal_places <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero with auto length, with and without a fraction.
    drive_number(16'sd0, -4'sd1, 2'd0);
    drive_number(16'sd0, -4'sd1, 2'd1);
    drive_number(16'sd0, -4'sd1, 2'd2);
    // Value extremes, including the most negative value.
    drive_number(-16'sd32768, -4'sd1, 2'd0);
    drive_number(-16'sd32768, 4'sd5, 2'd2);
    drive_number(16'sd32767, -4'sd1, 2'd0);
    drive_number(16'sd32767, 4'sd5, 2'd2);
    drive_number(-16'sd1, -4'sd1, 2'd0);
    drive_number(-16'sd32767, 4'sd3, 2'd0);
    // Field length of zero, below zero and above five.
    drive_number(16'sd1, 4'sd0, 2'd0);
    drive_number(16'sd42, -4'sd8, 2'd0);
    drive_number(-16'sd5, -4'sd2, 2'd3);
    drive_number(16'sd42, 4'sd7, 2'd1);
    drive_number(16'sd7, 4'sd6, 2'd2);
    // Three places saturate to two.
    drive_number(16'sd123, 4'sd3, 2'd3);
    // No integer digits: the output begins at the point or the sign.
    drive_number(16'sd5, 4'sd1, 2'd2);
    drive_number(-16'sd7, 4'sd1, 2'd2);
    // Short fields drop the upper digits; then more auto-length and fixed-length cases.
    drive_number(16'sd12345, 4'sd2, 2'd0);
    drive_number(16'sd100, -4'sd1, 2'd1);
    drive_number(-16'sd250, -4'sd1, 2'd2);
    drive_number(16'sd9, 4'sd4, 2'd1);
    drive_number(16'sd10000, -4'sd1, 2'd0);
    drive_number(16'sd0, 4'sd5, 2'd0);

    for (int i = 0; i < RANDOM_NUMBERS; i++) drive_random_number();
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Formatted %0d numbers into %0d checked characters.", sb.numbers,
             sb.chars_checked);
    $display("Of those, %0d were negative and %0d used leading-zero suppression.",
             sb.negatives, sb.auto_numbers);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
